// ===== hdl/imrt_pkg.sv =====
// ----------------------------------------------------------------------------
// imrt_pkg
// Shared types and codes for the IPv4 to MAC resolution table.
// ----------------------------------------------------------------------------
package imrt_pkg;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // operation codes on the input tuser
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // field widths
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    typedef logic [1:0]       status_t;
    typedef logic [IP_W-1:0]  ip_t;
    typedef logic [MAC_W-1:0] mac_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    latch_key;
        logic    add_write;
        logic    direct_read;
        logic    scan_start;
        logic    scan_step;
        logic    stage_load;
        logic    stage_mac;
        status_t stage_status;
        logic    out_load;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic direct_mode;
        logic in_range;
        logic scan_match;
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

// ===== hdl/imrt_datapath.sv =====
// ----------------------------------------------------------------------------
// imrt_datapath
// Entry memories, fill count, key registers, scan compare and result regs.
// ----------------------------------------------------------------------------
module imrt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  imrt_pkg::cmd_t          cmd,
    output imrt_pkg::stat_t         stat,
    input  imrt_pkg::ip_t           in_ip,
    input  imrt_pkg::mac_t          in_mac,
    input  logic                    cfg_we,
    input  logic                    cfg_mode,
    input  logic                    out_ready,
    output logic                    out_valid,
    output imrt_pkg::status_t       out_status,
    output imrt_pkg::mac_t          out_mac
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // entry memories
    imrt_pkg::ip_t  ip_mem  [TABLE_DEPTH];
    imrt_pkg::mac_t mac_mem [TABLE_DEPTH];

    // control registers
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          mode_reg, mode_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    imrt_pkg::ip_t     key_ip_reg;
    imrt_pkg::mac_t    key_mac_reg;
    imrt_pkg::ip_t     base_ip_reg;
    imrt_pkg::ip_t     ip_rd_reg;
    imrt_pkg::mac_t    mac_rd_reg;
    imrt_pkg::status_t stage_status_reg;
    imrt_pkg::mac_t    stage_mac_reg;
    imrt_pkg::status_t out_status_reg;
    imrt_pkg::mac_t    out_mac_reg;

    logic                  scan_issue;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    imrt_pkg::ip_t         offset;

    // offset from the first entry for direct mode
    assign offset     = key_ip_reg - base_ip_reg;
    assign scan_issue = cmd.scan_step && (scan_idx_reg < fill_reg);
    assign rd_en      = cmd.direct_read || scan_issue;
    assign rd_addr    = cmd.direct_read ? offset[AW-1:0] : scan_idx_reg[AW-1:0];

    // status toward the controller
    always_comb
    begin
        stat.full        = (fill_reg == CW'(TABLE_DEPTH));
        stat.empty       = (fill_reg == '0);
        stat.direct_mode = mode_reg;
        stat.in_range    = (offset < imrt_pkg::IP_W'(fill_reg));
        stat.scan_match  = rd_valid_reg && (ip_rd_reg == key_ip_reg);
        stat.scan_done   = !rd_valid_reg && !(scan_idx_reg < fill_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // next values of control state
    always_comb
    begin
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        rd_valid_next  = rd_valid_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        if (cmd.add_write)
        begin
            fill_next = fill_reg + CW'(1);
        end
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
            rd_valid_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            rd_valid_next = scan_issue;
            if (scan_issue)
            begin
                scan_idx_next = scan_idx_reg + CW'(1);
            end
        end
        if (cfg_we)
        begin
            mode_next = cfg_mode;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            scan_idx_reg  <= scan_idx_next;
            rd_valid_reg  <= rd_valid_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            ip_mem[fill_reg[AW-1:0]]  <= key_ip_reg;
            mac_mem[fill_reg[AW-1:0]] <= key_mac_reg;
        end
        if (rd_en)
        begin
            ip_rd_reg  <= ip_mem[rd_addr];
            mac_rd_reg <= mac_mem[rd_addr];
        end
    end

    // key, first entry ip, staged and output result
    always_ff @(posedge clk)
    begin
        if (cmd.latch_key)
        begin
            key_ip_reg  <= in_ip;
            key_mac_reg <= in_mac;
        end
        if (cmd.add_write && (fill_reg == '0))
        begin
            base_ip_reg <= key_ip_reg;
        end
        if (cmd.stage_load)
        begin
            stage_status_reg <= cmd.stage_status;
            stage_mac_reg    <= cmd.stage_mac ? mac_rd_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= stage_status_reg;
            out_mac_reg    <= stage_mac_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_mac    = out_mac_reg;

endmodule

// ===== hdl/imrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// imrt_ctrl
// Controller state machine sequencing add, direct lookup and scan lookup.
// ----------------------------------------------------------------------------
module imrt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_func,
    output logic            in_ready,
    input  imrt_pkg::stat_t stat,
    output imrt_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_DWAIT = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_key = 1'b1;
                    state_next    = (in_func == imrt_pkg::FUNC_LOOKUP) ? S_LOOK : S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.stage_load = 1'b1;
                if (stat.full)
                begin
                    cmd.stage_status = imrt_pkg::ST_FULL;
                end
                else
                begin
                    cmd.add_write    = 1'b1;
                    cmd.stage_status = imrt_pkg::ST_OK;
                end
                state_next = S_RESP;
            end
            S_LOOK:
            begin
                if (stat.empty || (stat.direct_mode && !stat.in_range))
                begin
                    cmd.stage_load   = 1'b1;
                    cmd.stage_status = imrt_pkg::ST_MISS;
                    state_next       = S_RESP;
                end
                else if (stat.direct_mode)
                begin
                    cmd.direct_read = 1'b1;
                    state_next      = S_DWAIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_DWAIT:
            begin
                cmd.stage_load   = 1'b1;
                cmd.stage_mac    = 1'b1;
                cmd.stage_status = imrt_pkg::ST_OK;
                state_next       = S_RESP;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_match)
                begin
                    cmd.stage_load   = 1'b1;
                    cmd.stage_mac    = 1'b1;
                    cmd.stage_status = imrt_pkg::ST_OK;
                    state_next       = S_RESP;
                end
                else if (stat.scan_done)
                begin
                    cmd.stage_load   = 1'b1;
                    cmd.stage_status = imrt_pkg::ST_MISS;
                    state_next       = S_RESP;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/ip_to_mac_resolution_table_unit.sv =====
// ----------------------------------------------------------------------------
// ip_to_mac_resolution_table_unit
// Append-only IPv4 to MAC table with search and direct-offset lookup.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tuser: func; tdata: ip_addr[31:0], mac_addr[79:32]
//  m_axis   | out       | tuser: status; tdata: found_mac[47:0]
//  cfg      | in        | data: direct_index_mode
//
//  one item at a time; add goes through S_ADD and S_RESP from accept to result register
//  direct lookup goes through S_LOOK, S_DWAIT and S_RESP, with one registered memory read
//  search lookup goes through S_LOOK, S_SCAN and S_RESP, one entry read per cycle
//  from the single read port of the entry memories
//  reset clears fill count and mode; entry memories are not cleared
//  a result waiting on m_axis stalls only the final load of the next result
// ----------------------------------------------------------------------------
module ip_to_mac_resolution_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // ip_addr[31:0], mac_addr[79:32]
    input  logic [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // found_mac[47:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data        // direct_index_mode[0]
);

    imrt_pkg::cmd_t  cmd;
    imrt_pkg::stat_t stat;

    // config beat always taken
    assign cfg_ready = 1'b1;

    imrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_ip      (s_axis_tdata[31:0]),
        .in_mac     (s_axis_tdata[79:32]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_mode   (cfg_data[0]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_mac    (m_axis_tdata)
    );

endmodule

// ===== hdl/imrt_checker.sv =====
// ----------------------------------------------------------------------------
// imrt_checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module imrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // items accepted but not yet delivered
    logic [1:0] pend_reg, pend_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_beat && !out_beat)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // status code in range
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == imrt_pkg::ST_OK) ||
            (m_axis_tuser == imrt_pkg::ST_FULL) || (m_axis_tuser == imrt_pkg::ST_MISS))
        else $error("undefined status code");

    // full or miss carries a zero mac
    a_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != imrt_pkg::ST_OK) |-> m_axis_tdata == '0)
        else $error("nonzero mac on full or miss");

    // every result follows an accepted item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pend_reg != 2'd0)
        else $error("result beat without pending item");

    // at most one item in work besides a result waiting on the output
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> pend_reg < 2'd2)
        else $error("item accepted while another is in work");

endmodule

bind ip_to_mac_resolution_table_unit imrt_checker u_imrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
